### rtl/sdcl_pkg.sv
// Shared types, sizes and relabelling functions for the small digraph canonical labeller.
package sdcl_pkg;

    localparam int VERTICES = 4;
    localparam int NB       = VERTICES * VERTICES;
    localparam int VI_W     = (VERTICES > 1) ? $clog2(VERTICES) : 1;
    localparam int LABEL_W  = 16;
    localparam int WIDE_W   = (NB > LABEL_W) ? NB : LABEL_W;

    function automatic int fact(input int n);
        int f;
        f = 1;
        for (int k = 2; k <= n; k++) begin
            f = f * k;
        end
        return f;
    endfunction

    localparam int PERMS = fact(VERTICES);

    typedef logic [VI_W-1:0]        t_vidx;
    typedef t_vidx [VERTICES-1:0]   t_perm;
    typedef logic [NB-1:0]          t_mat;
    typedef logic [LABEL_W-1:0]     t_label;
    typedef logic [WIDE_W-1:0]      t_wide;

    typedef struct packed {
        t_mat adj;
        t_mat best;
    } t_cell_data;

    // Next permutation in lexicographic order; the last one wraps to identity.
    function automatic t_perm next_perm(input t_perm p);
        t_perm q;
        t_vidx tmp;
        int    i;
        int    j;
        int    l;
        int    r;
        q = p;
        i = -1;
        for (int k = VERTICES - 2; k >= 0; k--) begin
            if (i < 0 && q[k] < q[k+1]) begin
                i = k;
            end
        end
        if (i >= 0) begin
            j = i + 1;
            for (int k = i + 1; k < VERTICES; k++) begin
                if (q[k] > q[i]) begin
                    j = k;
                end
            end
            tmp  = q[i];
            q[i] = q[j];
            q[j] = tmp;
        end
        l = i + 1;
        r = VERTICES - 1;
        for (int k = 0; k < VERTICES; k++) begin
            if (l < r) begin
                tmp  = q[l];
                q[l] = q[r];
                q[r] = tmp;
                l    = l + 1;
                r    = r - 1;
            end
        end
        return q;
    endfunction

    function automatic t_perm perm_at(input int n);
        t_perm p;
        for (int k = 0; k < VERTICES; k++) begin
            p[k] = t_vidx'(k);
        end
        for (int m = 0; m < n; m++) begin
            p = next_perm(p);
        end
        return p;
    endfunction

    // B[i][j] = A[p(i)][p(j)], row 0 column 0 in the top bit.
    function automatic t_mat relabel(input t_mat a, input t_perm p);
        t_mat res;
        for (int i = 0; i < VERTICES; i++) begin
            for (int j = 0; j < VERTICES; j++) begin
                res[NB-1-(i*VERTICES+j)] =
                    a[NB-1-(int'(p[i])*VERTICES + int'(p[j]))];
            end
        end
        return res;
    endfunction

    function automatic logic [VERTICES-1:0] diag(input t_mat m);
        logic [VERTICES-1:0] d;
        for (int i = 0; i < VERTICES; i++) begin
            d[i] = m[NB-1-(i*VERTICES+i)];
        end
        return d;
    endfunction

endpackage

### rtl/small_digraph_canonical_label.sv
// Top level of the small digraph canonical labeller: a chain of relabelling cells.
//
//   Channel  Ports              Width  Contents
//   in       s_axis_t*          16     adjacency_bits, row 0 column 0 in bit 15
//   out      m_axis_t*          16     canonical_label, same packing
//
// The design is a chain of PERMS cells (24 for four vertices), one for each vertex
// relabelling. Every cell holds one transaction, compares its own relabelled matrix
// against the running minimum and hands the result to its neighbor.
// One transaction is accepted per clock cycle while the output side takes data; each
// transaction passes through every cell of the chain in turn, and the last cell is the output register.
// Reset is synchronous and active low; it empties every cell.
// Each cell loads whenever it is empty or its neighbor takes its content, so a stall
// at the output fills the bubbles in the chain before the input side stops.
module small_digraph_canonical_label (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [15:0]             s_axis_tdata,   // [15:0] adjacency_bits
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [15:0]             m_axis_tdata    // [15:0] canonical_label
);
    import sdcl_pkg::*;

    // Handshake and payload at each boundary of the chain; index 0 is the input side.
    logic       chain_valid [0:PERMS];
    logic       chain_ready [0:PERMS];
    t_cell_data chain_data  [0:PERMS];

    t_wide in_wide;
    t_wide out_wide;

    // Input bits beyond the matrix are dropped; missing high bits read as zero.
    assign in_wide = t_wide'(s_axis_tdata);

    assign chain_valid[0]     = s_axis_tvalid;
    assign s_axis_tready      = chain_ready[0];
    assign chain_data[0].adj  = in_wide[NB-1:0];
    // The running minimum starts at all ones, so an all-ones matrix maps to itself.
    assign chain_data[0].best = '1;

    for (genvar k = 0; k < PERMS; k++) begin : g_cell
        localparam t_perm PERM_K = perm_at(k);

        sdcl_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_perm  (PERM_K),
            .i_valid (chain_valid[k]),
            .o_ready (chain_ready[k]),
            .i_data  (chain_data[k]),
            .o_valid (chain_valid[k+1]),
            .i_ready (chain_ready[k+1]),
            .o_data  (chain_data[k+1])
        );
    end

    assign chain_ready[PERMS] = m_axis_tready;
    assign m_axis_tvalid      = chain_valid[PERMS];
    assign out_wide           = t_wide'(chain_data[PERMS].best);
    assign m_axis_tdata       = out_wide[LABEL_W-1:0];

    // The identity relabelling is in the chain, so the label never exceeds the input.
    a_identity_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        chain_valid[PERMS] |-> chain_data[PERMS].best <= chain_data[PERMS].adj)
        else $error("canonical label larger than its own input matrix");

    // A relabelling moves self-loops along the diagonal but keeps their number.
    a_diag_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        chain_valid[PERMS] |->
            $countones(diag(chain_data[PERMS].best)) ==
            $countones(diag(chain_data[PERMS].adj)))
        else $error("canonical label changed the number of self-loops");

    // Reset must empty the whole chain, the output register included.
    a_reset_empty : assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("output valid right after reset");

endmodule

### rtl/sdcl_cell.sv
// One cell of the labelling chain: applies one fixed relabelling and keeps the running minimum.
module sdcl_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sdcl_pkg::t_perm    i_perm,
    input  logic               i_valid,
    output logic               o_ready,
    input  sdcl_pkg::t_cell_data i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output sdcl_pkg::t_cell_data o_data
);
    import sdcl_pkg::*;

    logic       r_valid;
    t_cell_data r_data;
    t_cell_data n_data;
    t_mat       cand;

    // The stage can load when it is empty or its content moves on.
    assign o_ready = !r_valid || i_ready;

    always_comb begin
        cand        = relabel(i_data.adj, i_perm);
        n_data.adj  = i_data.adj;
        n_data.best = (cand < i_data.best) ? cand : i_data.best;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule
